FILE: sv/bilin_pkg.sv
// Package for the bilinear root mapper: widths, constants and the flag record
// carried beside the datapath. No dependencies.
`default_nettype none
package bilin_pkg;

   localparam int SR_W      = 20;   // sample rate register
   localparam int ROOT_W    = 40;   // s-plane root parts, 16 fraction bits
   localparam int F_W       = 37;   // 2*fs*2^16
   localparam int QM_W      = 41;   // |F - a|
   localparam int MAG_W     = 40;   // |a|, |b|
   localparam int MUL_W     = 42;   // multiplier operand
   localparam int HALF_W    = 21;   // operand half
   localparam int PROD_W    = 84;   // multiplier product
   localparam int DEN_W     = 83;   // (F-a)^2 + b^2
   localparam int NUM_W     = 81;   // |F^2 - a^2 - b^2|, 2*F*b
   localparam int REM_W     = 117;  // divider remainder
   localparam int Z_W       = 32;   // Q2.30 result
   localparam int DIV_STEPS = 32;
   localparam int DIV_LAT   = DIV_STEPS + 1;

   localparam logic [SR_W-1:0] SR_RESET    = 20'd44100;
   localparam logic [Z_W-1:0]  Z_MINUS_ONE = 32'hC000_0000;
   localparam logic [Z_W-1:0]  Z_POS_MAX   = 32'h7FFF_FFFF;
   localparam logic [Z_W-1:0]  Z_NEG_MAX   = 32'h8000_0000;

   typedef struct packed {
      logic valid;
      logic inf;
      logic last;
      logic im_neg;
      logic re_neg;
      logic den_zero;
   } flags_type;

endpackage
`default_nettype wire

FILE: sv/bilin_mul.sv
// Two-stage 42x42 unsigned multiplier built from four half-width products.
// Uses bilin_pkg.
`default_nettype none
module bilin_mul (
   input  wire logic                          clock,
   input  wire logic [bilin_pkg::MUL_W-1:0]   x,
   input  wire logic [bilin_pkg::MUL_W-1:0]   y,
   output logic      [bilin_pkg::PROD_W-1:0]  p
);

   localparam int HW = bilin_pkg::HALF_W;
   localparam int PW = bilin_pkg::PROD_W;

   logic [2*HW-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [PW-1:0]   p_ff;
   logic [PW-1:0]   p_in;

   always_ff @(posedge clock) begin
      ll_ff <= x[HW-1:0]    * y[HW-1:0];
      lh_ff <= x[HW-1:0]    * y[2*HW-1:HW];
      hl_ff <= x[2*HW-1:HW] * y[HW-1:0];
      hh_ff <= x[2*HW-1:HW] * y[2*HW-1:HW];
   end

   always_comb begin
      p_in = (PW'(hh_ff) << (2*HW)) + (PW'(lh_ff) << HW) + (PW'(hl_ff) << HW)
           + PW'(ll_ff);
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

FILE: sv/bilin_div.sv
// Pipelined restoring divider: round(num*2^30/den) as 32 bits plus overflow.
// One quotient bit per stage. Uses bilin_pkg.
`default_nettype none
module bilin_div (
   input  wire logic                          clock,
   input  wire logic [bilin_pkg::NUM_W-1:0]   num,
   input  wire logic [bilin_pkg::DEN_W-1:0]   den,
   output logic      [bilin_pkg::Z_W-1:0]     quot,
   output logic                               ovf
);

   localparam int RW = bilin_pkg::REM_W;
   localparam int NS = bilin_pkg::DIV_STEPS;
   localparam int QW = bilin_pkg::Z_W;

   logic [RW-1:0] rem_ff [0:NS];
   logic [RW-1:0] d2_ff  [0:NS];
   logic [QW-1:0] q_ff   [0:NS];
   logic          ovf_ff [0:NS];

   // r = 2*num*2^30 + den over divisor 2*den gives round-half-away
   always_ff @(posedge clock) begin
      rem_ff[0] <= (RW'(num) << 31) + RW'(den);
      d2_ff[0]  <= RW'(den) << 1;
      q_ff[0]   <= '0;
      ovf_ff[0] <= 1'b0;
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      localparam int SH = NS - k;
      logic [RW-1:0] trial;
      logic          take;

      always_comb begin
         trial = d2_ff[k-1] << SH;
         take  = (rem_ff[k-1] >= trial);
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? (rem_ff[k-1] - trial) : rem_ff[k-1];
         d2_ff[k]  <= d2_ff[k-1];
         q_ff[k]   <= {q_ff[k-1][QW-2:0], take};
      end

      if (k == 1) begin : g_ovf
         always_ff @(posedge clock) begin
            ovf_ff[k] <= ovf_ff[k-1] | (rem_ff[k-1] >= (d2_ff[k-1] << QW));
         end
      end else begin : g_pass
         always_ff @(posedge clock) begin
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[NS];
   assign ovf  = ovf_ff[NS];

endmodule
`default_nettype wire

FILE: sv/bilinear_root_mapper_unit.sv
// Top level of the bilinear-transform root mapper: z = (1+w)/(1-w), w = s/(2fs).
// Uses bilin_pkg, bilin_mul and bilin_div.
//
//   channel   ports                        handshake
//   request   req_root_*, start, busy      beat on start && !busy
//   response  rsp_z_*, rsp_*, rsp_strobe   one-cycle beat, no back-pressure
//   config    csr_write_en/csr_write_data  write on csr_write_en
//
// One root per cycle; busy stays low. Each result strobes after its request beat
// passes the input, magnitude, two multiplier and two sum stages, then the 33-stage
// divider (an input stage, then one quotient bit per stage) and the output register.
// Synchronous reset clears the valid bits and restores sample_rate to 44100.
// The receiver cannot stall, so nothing in the pipe ever holds.
`default_nettype none
module bilinear_root_mapper_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [bilin_pkg::ROOT_W-1:0] req_root_re,
   input  wire logic signed [bilin_pkg::ROOT_W-1:0] req_root_im,
   input  wire logic                              req_root_infinite,
   input  wire logic                              req_root_last,
   input  wire logic                              csr_write_en,
   input  wire logic [bilin_pkg::SR_W-1:0]        csr_write_data,
   output logic                                   rsp_strobe,
   output logic signed [bilin_pkg::Z_W-1:0]       rsp_z_re,
   output logic signed [bilin_pkg::Z_W-1:0]       rsp_z_im,
   output logic                                   rsp_saturated,
   output logic                                   rsp_out_last
);

   localparam int RTW = bilin_pkg::ROOT_W;
   localparam int FW  = bilin_pkg::F_W;
   localparam int QMW = bilin_pkg::QM_W;
   localparam int MGW = bilin_pkg::MAG_W;
   localparam int MW  = bilin_pkg::MUL_W;
   localparam int PW  = bilin_pkg::PROD_W;
   localparam int DW  = bilin_pkg::DEN_W;
   localparam int NW  = bilin_pkg::NUM_W;
   localparam int ZW  = bilin_pkg::Z_W;
   localparam int LAT = bilin_pkg::DIV_LAT;

   logic [bilin_pkg::SR_W-1:0] sample_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= bilin_pkg::SR_RESET;
      end else if (csr_write_en) begin
         sample_rate_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   // stage 1: input capture
   bilin_pkg::flags_type fl1_ff, fl1_in;
   logic [RTW-1:0] re1_ff, im1_ff;

   always_comb begin
      fl1_in          = '0;
      fl1_in.valid    = start & ~busy;
      fl1_in.inf      = req_root_infinite;
      fl1_in.last     = req_root_last;
      fl1_in.im_neg   = req_root_im[RTW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl1_ff <= '0;
      end else begin
         fl1_ff <= fl1_in;
      end
      re1_ff <= req_root_re;
      im1_ff <= req_root_im;
   end

   // stage 2: magnitudes and |F - a|
   bilin_pkg::flags_type fl2_ff;
   logic [QMW-1:0] qm2_ff, qm2_in;
   logic [MGW-1:0] am2_ff, am2_in, bm2_ff, bm2_in;
   logic [FW-1:0]  f2_ff, f2_in;
   logic [QMW:0]   diff;

   always_comb begin
      f2_in  = {sample_rate_ff, 17'b0};
      diff   = (QMW+1)'(f2_in) - {{2{re1_ff[RTW-1]}}, re1_ff};
      qm2_in = diff[QMW] ? QMW'(-diff) : diff[QMW-1:0];
      am2_in = re1_ff[RTW-1] ? MGW'(-re1_ff) : re1_ff;
      bm2_in = im1_ff[RTW-1] ? MGW'(-im1_ff) : im1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl2_ff <= '0;
      end else begin
         fl2_ff <= fl1_ff;
      end
      qm2_ff <= qm2_in;
      am2_ff <= am2_in;
      bm2_ff <= bm2_in;
      f2_ff  <= f2_in;
   end

   // stages 3-4: products
   logic [PW-1:0] qq_p, aa_p, bb_p, ff_p, fb_p;

   bilin_mul u_mul_qq (.clock(clock), .x(MW'(qm2_ff)), .y(MW'(qm2_ff)), .p(qq_p));
   bilin_mul u_mul_aa (.clock(clock), .x(MW'(am2_ff)), .y(MW'(am2_ff)), .p(aa_p));
   bilin_mul u_mul_bb (.clock(clock), .x(MW'(bm2_ff)), .y(MW'(bm2_ff)), .p(bb_p));
   bilin_mul u_mul_ff (.clock(clock), .x(MW'(f2_ff)),  .y(MW'(f2_ff)),  .p(ff_p));
   bilin_mul u_mul_fb (.clock(clock), .x(MW'({f2_ff, 1'b0})), .y(MW'(bm2_ff)),
                       .p(fb_p));

   bilin_pkg::flags_type fl3_ff, fl4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fl3_ff <= '0;
         fl4_ff <= '0;
      end else begin
         fl3_ff <= fl2_ff;
         fl4_ff <= fl3_ff;
      end
   end

   // stage 5: denominator and a^2 + b^2
   bilin_pkg::flags_type fl5_ff;
   logic [DW-1:0] den5_ff;
   logic [NW-1:0] ab5_ff, ff5_ff, nim5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fl5_ff <= '0;
      end else begin
         fl5_ff <= fl4_ff;
      end
      den5_ff <= DW'(qq_p) + DW'(bb_p);
      ab5_ff  <= NW'(aa_p) + NW'(bb_p);
      ff5_ff  <= NW'(ff_p);
      nim5_ff <= NW'(fb_p);
   end

   // stage 6: real numerator and special flags
   bilin_pkg::flags_type fl6_ff, fl6_in;
   logic [DW-1:0] den6_ff;
   logic [NW-1:0] nre6_ff, nre6_in, nim6_ff;

   always_comb begin
      fl6_in          = fl5_ff;
      fl6_in.re_neg   = (ab5_ff > ff5_ff);
      fl6_in.den_zero = (den5_ff == '0);
      nre6_in         = fl6_in.re_neg ? (ab5_ff - ff5_ff) : (ff5_ff - ab5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl6_ff <= '0;
      end else begin
         fl6_ff <= fl6_in;
      end
      den6_ff <= den5_ff;
      nre6_ff <= nre6_in;
      nim6_ff <= nim5_ff;
   end

   // divider lanes
   logic [ZW-1:0] q_re, q_im;
   logic          ovf_re, ovf_im;

   bilin_div u_div_re (.clock(clock), .num(nre6_ff), .den(den6_ff),
                       .quot(q_re), .ovf(ovf_re));
   bilin_div u_div_im (.clock(clock), .num(nim6_ff), .den(den6_ff),
                       .quot(q_im), .ovf(ovf_im));

   bilin_pkg::flags_type fld_ff [0:LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            fld_ff[i] <= '0;
         end
      end else begin
         fld_ff[0] <= fl6_ff;
         for (int i = 1; i < LAT; i++) begin
            fld_ff[i] <= fld_ff[i-1];
         end
      end
   end

   // output: sign, clipping, special cases
   bilin_pkg::flags_type flo;
   logic [ZW-1:0] zre_in, zim_in;
   logic          sat_re, sat_im, sat_in;
   logic          strobe_ff;
   logic [ZW-1:0] zre_ff, zim_ff;
   logic          sat_ff, last_ff;

   always_comb begin
      flo    = fld_ff[LAT-1];
      sat_re = 1'b0;
      sat_im = 1'b0;
      if (!flo.re_neg) begin
         if (ovf_re || q_re > bilin_pkg::Z_POS_MAX) begin
            sat_re = 1'b1;
            zre_in = bilin_pkg::Z_POS_MAX;
         end else begin
            zre_in = q_re;
         end
      end else begin
         if (ovf_re || q_re > bilin_pkg::Z_NEG_MAX) begin
            sat_re = 1'b1;
            zre_in = bilin_pkg::Z_NEG_MAX;
         end else begin
            zre_in = -q_re;
         end
      end
      if (!flo.im_neg) begin
         if (ovf_im || q_im > bilin_pkg::Z_POS_MAX) begin
            sat_im = 1'b1;
            zim_in = bilin_pkg::Z_POS_MAX;
         end else begin
            zim_in = q_im;
         end
      end else begin
         if (ovf_im || q_im > bilin_pkg::Z_NEG_MAX) begin
            sat_im = 1'b1;
            zim_in = bilin_pkg::Z_NEG_MAX;
         end else begin
            zim_in = -q_im;
         end
      end
      sat_in = sat_re | sat_im;
      if (flo.inf) begin
         zre_in = bilin_pkg::Z_MINUS_ONE;
         zim_in = '0;
         sat_in = 1'b0;
      end else if (flo.den_zero) begin
         zre_in = bilin_pkg::Z_POS_MAX;
         zim_in = '0;
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= flo.valid;
      end
      zre_ff  <= zre_in;
      zim_ff  <= zim_in;
      sat_ff  <= sat_in;
      last_ff <= flo.last;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_z_re      = zre_ff;
   assign rsp_z_im      = zim_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_out_last  = last_ff;

endmodule
`default_nettype wire
